// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl modules
// no dependencies; included by crcfr_frame_core, the one file that carries assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/crcfr_pkg.sv =====
// types, constants and the byte-wide crc-32 step of the frame receiver
// no dependencies
package crcfr_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
  localparam int COUNT_W      = 13;
  localparam int CFG_ADDR_W   = 3;

  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t HDR_END    = count_t'(HEADER_BYTES);
  localparam count_t HDR_LAST   = count_t'(HEADER_BYTES - 1);
  localparam count_t HCRC_BYTES = count_t'(28);
  localparam count_t LEN_CAP    = 13'd4096;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_WORD   = 32'h3153_314B;
  localparam logic [31:0] VERSION_WORD = 32'd1;

  localparam count_t      MAX_PAYLOAD_RESET = 13'd360;
  localparam logic [31:0] TIMEOUT_RESET     = 32'd2000;

  // register index taken from paddr bit 2
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  typedef enum logic [1:0] {
    CMD_RX_BYTE,
    CMD_POLL,
    CMD_REPLY_SENT,
    CMD_DISCONNECT
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_FRAME_OK,
    ST_BAD_HEADER,
    ST_TOO_LONG,
    ST_CRC_BAD,
    ST_TIMEOUT
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  rx_byte;
    logic [31:0] now_time;
  } item_t;

  typedef struct packed {
    count_t      max_payload_bytes;
    logic [31:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    status_t     status_code;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [11:0] payload_offset;
    logic [31:0] frame_command;
    logic [31:0] request_id;
    logic [31:0] frame_sequence;
    count_t      payload_length;
    logic [31:0] rejected_count;
  } result_t;

  // reflected crc-32, one byte per call
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'h0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcfr_if.sv =====
// request and result channels of the frame receiver
// no dependencies
interface crcfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  rx_byte;
  logic [31:0] now_time;

  modport source (output valid, cmd, rx_byte, now_time, input ready);
  modport sink (input valid, cmd, rx_byte, now_time, output ready);
endinterface

interface crcfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status_code;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [11:0] payload_offset;
  logic [31:0] frame_command;
  logic [31:0] request_id;
  logic [31:0] frame_sequence;
  logic [12:0] payload_length;
  logic [31:0] rejected_count;

  modport source (output valid, status_code, payload_valid, payload_byte, payload_offset,
                  frame_command, request_id, frame_sequence, payload_length,
                  rejected_count, input ready);
  modport sink (input valid, status_code, payload_valid, payload_byte, payload_offset,
                frame_command, request_id, frame_sequence, payload_length,
                rejected_count, output ready);
endinterface

// ===== rtl/crc_checked_frame_receiver.sv =====
// Frame receiver top level: input register, frame core, result register and apb registers.
// Takes one request (received byte, poll tick, reply sent or disconnect) per clock and
// returns exactly one result per request through the input register and then the result
// register. The header check, the byte-wide payload crc-32 and the status decision sit
// between the two registers, so the sustained rate is one request per cycle as long as the
// result side takes results; while a finished result waits, only an empty input register
// takes a new request. The header store needs no clearing after reset.
// depends on crcfr_pkg, crcfr_if, crcfr_cfg_regs and crcfr_frame_core
module crc_checked_frame_receiver (
  input  logic                             clk,
  input  logic                             rst,
  crcfr_in_if.sink                         item_in,
  crcfr_out_if.source                      result_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crcfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  crcfr_pkg::cfg_t    cfg;
  crcfr_pkg::item_t   in_item;
  crcfr_pkg::result_t core_res, res;
  logic               in_valid, res_valid;
  logic               advance, in_ready, step;

  crcfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the result register frees up when empty or taken this cycle
  assign advance       = !res_valid || result_out.ready;
  assign in_ready      = !in_valid || advance;
  assign step          = in_valid && advance;
  assign item_in.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && item_in.valid) begin
      in_item.cmd      <= crcfr_pkg::cmd_t'(item_in.cmd);
      in_item.rx_byte  <= item_in.rx_byte;
      in_item.now_time <= item_in.now_time;
    end
  end

  crcfr_frame_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= core_res;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.status_code    = res.status_code;
  assign result_out.payload_valid  = res.payload_valid;
  assign result_out.payload_byte   = res.payload_byte;
  assign result_out.payload_offset = res.payload_offset;
  assign result_out.frame_command  = res.frame_command;
  assign result_out.request_id     = res.request_id;
  assign result_out.frame_sequence = res.frame_sequence;
  assign result_out.payload_length = res.payload_length;
  assign result_out.rejected_count = res.rejected_count;

endmodule

// ===== rtl/crcfr_cfg_regs.sv =====
// apb register file: payload length limit and timeout
// depends on crcfr_pkg
module crcfr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [crcfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output crcfr_pkg::cfg_t                  cfg
);

  crcfr_pkg::count_t max_payload_bytes;
  logic [31:0]       timeout_ticks;
  logic              wr_en;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= crcfr_pkg::MAX_PAYLOAD_RESET;
      timeout_ticks     <= crcfr_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        crcfr_pkg::REG_MAX_PAYLOAD: max_payload_bytes <= pwdata[crcfr_pkg::COUNT_W-1:0];
        crcfr_pkg::REG_TIMEOUT:     timeout_ticks     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      crcfr_pkg::REG_MAX_PAYLOAD: prdata = {19'h0, max_payload_bytes};
      crcfr_pkg::REG_TIMEOUT:     prdata = timeout_ticks;
      default:                    prdata = 32'h0;
    endcase
  end

  assign cfg.max_payload_bytes = max_payload_bytes;
  assign cfg.timeout_ticks     = timeout_ticks;

endmodule

// ===== rtl/crcfr_frame_core.sv =====
// framing state, header checks, payload crc and status for one request a cycle while step is high
// depends on crcfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module crcfr_frame_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  crcfr_pkg::item_t   item,
  input  crcfr_pkg::cfg_t    cfg,
  output crcfr_pkg::result_t res
);

  logic [7:0]        hdr_mem [crcfr_pkg::HEADER_BYTES];
  crcfr_pkg::count_t byte_count, byte_count_next;
  crcfr_pkg::count_t frame_end, frame_end_next;
  logic [31:0]       start_time, start_time_next;
  logic              reply_pending, reply_pending_next;
  logic [31:0]       rejected_total, rejected_total_next;
  logic [31:0]       crc, crc_next;

  logic              rx, in_header, hdr_last, hdr_wr;
  logic              magic_ok, version_ok, hcrc_ok, len_over;
  logic [31:0]       crc_upd, elapsed;
  logic [31:0]       w_magic, w_cmd, w_id, w_seq, w_len, w_pcrc, w_ver, w_hcrc;
  crcfr_pkg::count_t limit, count_inc, offset_full;
  crcfr_pkg::status_t status;
  logic              show_hdr, pv;

  assign w_magic = {hdr_mem[3], hdr_mem[2], hdr_mem[1], hdr_mem[0]};
  assign w_cmd   = {hdr_mem[7], hdr_mem[6], hdr_mem[5], hdr_mem[4]};
  assign w_id    = {hdr_mem[11], hdr_mem[10], hdr_mem[9], hdr_mem[8]};
  assign w_seq   = {hdr_mem[15], hdr_mem[14], hdr_mem[13], hdr_mem[12]};
  assign w_len   = {hdr_mem[19], hdr_mem[18], hdr_mem[17], hdr_mem[16]};
  assign w_pcrc  = {hdr_mem[23], hdr_mem[22], hdr_mem[21], hdr_mem[20]};
  assign w_ver   = {hdr_mem[27], hdr_mem[26], hdr_mem[25], hdr_mem[24]};
  // last header byte arrives with this request
  assign w_hcrc  = {item.rx_byte, hdr_mem[30], hdr_mem[29], hdr_mem[28]};

  assign rx        = step && (item.cmd == crcfr_pkg::CMD_RX_BYTE) && !reply_pending;
  assign in_header = byte_count < crcfr_pkg::HDR_END;
  assign hdr_last  = byte_count == crcfr_pkg::HDR_LAST;
  assign hdr_wr    = rx && in_header;
  assign count_inc = byte_count + 13'd1;
  assign crc_upd   = crcfr_pkg::crc32_byte(crc, item.rx_byte);
  assign elapsed   = item.now_time - start_time;
  assign limit     = (cfg.max_payload_bytes > crcfr_pkg::LEN_CAP) ? crcfr_pkg::LEN_CAP
                                                                   : cfg.max_payload_bytes;

  assign magic_ok   = w_magic == crcfr_pkg::MAGIC_WORD;
  assign version_ok = w_ver == crcfr_pkg::VERSION_WORD;
  // crc register holds the crc over header bytes 0 to 27 at this point
  assign hcrc_ok    = ~crc == w_hcrc;
  assign len_over   = w_len > {19'h0, limit};

  always_comb begin
    status   = crcfr_pkg::ST_NONE;
    show_hdr = 1'b0;
    pv       = 1'b0;
    if (rx) begin
      if (in_header) begin
        if (hdr_last) begin
          show_hdr = 1'b1;
          if (!(magic_ok && version_ok && hcrc_ok)) begin
            status = crcfr_pkg::ST_BAD_HEADER;
          end else if (len_over) begin
            status = crcfr_pkg::ST_TOO_LONG;
          end else if (w_len == 32'h0) begin
            // empty payload: its crc reads as zero
            status = (w_pcrc == 32'h0) ? crcfr_pkg::ST_FRAME_OK : crcfr_pkg::ST_CRC_BAD;
          end
        end
      end else begin
        show_hdr = 1'b1;
        pv       = 1'b1;
        if (count_inc == frame_end) begin
          status = (~crc_upd == w_pcrc) ? crcfr_pkg::ST_FRAME_OK : crcfr_pkg::ST_CRC_BAD;
        end
      end
    end else if (step && item.cmd == crcfr_pkg::CMD_POLL) begin
      if (byte_count != '0 && elapsed > cfg.timeout_ticks) begin
        status   = crcfr_pkg::ST_TIMEOUT;
        show_hdr = !in_header;
      end
    end
  end

  always_comb begin
    byte_count_next     = byte_count;
    frame_end_next      = frame_end;
    start_time_next     = start_time;
    reply_pending_next  = reply_pending;
    rejected_total_next = rejected_total;
    crc_next            = crc;

    if (rx) begin
      if (byte_count == '0) begin
        start_time_next = item.now_time;
      end
      byte_count_next = count_inc;
      if (in_header) begin
        if (byte_count < crcfr_pkg::HCRC_BYTES) begin
          crc_next = crc_upd;
        end
        if (hdr_last) begin
          frame_end_next = crcfr_pkg::HDR_END + w_len[crcfr_pkg::COUNT_W-1:0];
          crc_next       = crcfr_pkg::CRC_ONES;
        end
      end else begin
        crc_next = crc_upd;
      end
    end

    if (step) begin
      case (item.cmd)
        crcfr_pkg::CMD_RX_BYTE: ;
        crcfr_pkg::CMD_POLL: ;
        crcfr_pkg::CMD_REPLY_SENT: reply_pending_next = 1'b0;
        crcfr_pkg::CMD_DISCONNECT: begin
          byte_count_next    = '0;
          frame_end_next     = crcfr_pkg::HDR_END;
          crc_next           = crcfr_pkg::CRC_ONES;
          reply_pending_next = 1'b0;
        end
        default: ;
      endcase
    end

    // any report restarts framing and waits for the reply
    if (status != crcfr_pkg::ST_NONE) begin
      if (status != crcfr_pkg::ST_FRAME_OK) begin
        rejected_total_next = rejected_total + 32'd1;
      end
      reply_pending_next = 1'b1;
      byte_count_next    = '0;
      frame_end_next     = crcfr_pkg::HDR_END;
      crc_next           = crcfr_pkg::CRC_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      frame_end      <= crcfr_pkg::HDR_END;
      start_time     <= '0;
      reply_pending  <= 1'b0;
      rejected_total <= '0;
      crc            <= crcfr_pkg::CRC_ONES;
    end else begin
      byte_count     <= byte_count_next;
      frame_end      <= frame_end_next;
      start_time     <= start_time_next;
      reply_pending  <= reply_pending_next;
      rejected_total <= rejected_total_next;
      crc            <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_mem[byte_count[crcfr_pkg::HDR_IDX_W-1:0]] <= item.rx_byte;
    end
  end

  assign offset_full = byte_count - crcfr_pkg::HDR_END;

  always_comb begin
    res.status_code    = status;
    res.payload_valid  = pv;
    res.payload_byte   = pv ? item.rx_byte : 8'h0;
    res.payload_offset = pv ? offset_full[11:0] : 12'h0;
    res.frame_command  = show_hdr ? w_cmd : 32'h0;
    res.request_id     = show_hdr ? w_id : 32'h0;
    res.frame_sequence = show_hdr ? w_seq : 32'h0;
    res.payload_length = '0;
    if (show_hdr) begin
      res.payload_length = (w_len > {19'h0, crcfr_pkg::LEN_CAP}) ? crcfr_pkg::LEN_CAP
                                                                : w_len[crcfr_pkg::COUNT_W-1:0];
    end
    res.rejected_count = rejected_total_next;
  end

  `ASSERT_CLK(a_pending_no_frame, clk, rst, reply_pending |-> byte_count == '0, "reply pending with a partial frame")
  `ASSERT_CLK(a_count_within_frame, clk, rst, byte_count <= frame_end && frame_end >= crcfr_pkg::HDR_END, "byte count ran past frame end")
  `ASSERT_NEXT(a_report_restarts, clk, rst, step && res.status_code != crcfr_pkg::ST_NONE, byte_count == '0 && reply_pending, "report did not restart framing")
  `ASSERT_CLK(a_payload_status, clk, rst, res.payload_valid |-> (res.status_code == crcfr_pkg::ST_NONE || res.status_code == crcfr_pkg::ST_FRAME_OK || res.status_code == crcfr_pkg::ST_CRC_BAD), "payload byte with a header or timeout status")

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for crc_checked_frame_receiver: framed byte traffic, polls,
// replies and disconnects against a cycle-free predictor, with random idling on both sides
// depends on crcfr_pkg, crcfr_if and the receiver rtl
`timescale 1ns / 1ps

module testbench;

  localparam int          RESULT_LATENCY = 2;
  localparam int          LONG_HOLD      = 300;
  localparam int          RANDOM_ITEMS   = 900;
  localparam int          CONFIG_PHASES  = 6;
  localparam int unsigned CYCLE_LIMIT    = 4_000_000;

  typedef enum {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_HEADER_CRC,
    FLAW_LENGTH,
    FLAW_PAYLOAD_CRC
  } frame_flaw_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [crcfr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crcfr_in_if  in_if ();
  crcfr_out_if out_if ();

  crc_checked_frame_receiver DUT (
    .clk        (clk),
    .rst        (rst),
    .item_in    (in_if),
    .result_out (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  hdr_bytes [crcfr_pkg::HEADER_BYTES];
  int unsigned bytes_seen;
  logic [31:0] frame_end_count;
  logic [31:0] frame_start_time;
  bit          awaiting_reply;
  logic [31:0] reject_total;
  logic [31:0] payload_crc;
  crcfr_pkg::count_t cfg_max_payload;
  logic [31:0] cfg_timeout;

  crcfr_pkg::result_t awaited_results [$];
  logic [31:0] clock_now;
  bit          burst_mode;
  bit          hold_req;
  int          hold_left;
  int          stall_left;
  int          items_sent;
  int          results_checked;
  int          mismatch_count;
  int          status_tally [6];
  int unsigned cycle_count;

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc;
    // bit-serial form, data lsb first
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ data[k]) c = (c >> 1) ^ crcfr_pkg::CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic logic [31:0] hdr_word(int pos);
    return {hdr_bytes[pos+3], hdr_bytes[pos+2], hdr_bytes[pos+1], hdr_bytes[pos]};
  endfunction

  function automatic bit header_intact();
    logic [31:0] c;
    c = crcfr_pkg::CRC_ONES;
    if (hdr_word(0) != crcfr_pkg::MAGIC_WORD || hdr_word(24) != crcfr_pkg::VERSION_WORD)
      return 1'b0;
    for (int i = 0; i < int'(crcfr_pkg::HCRC_BYTES); i++) c = crc_step(c, hdr_bytes[i]);
    return (~c) == hdr_word(28);
  endfunction

  function automatic int limit_now();
    return (cfg_max_payload > crcfr_pkg::LEN_CAP) ? int'(crcfr_pkg::LEN_CAP)
                                                  : int'(cfg_max_payload);
  endfunction

  function automatic crcfr_pkg::result_t receiver_response(crcfr_pkg::item_t it);
    crcfr_pkg::result_t r;
    bit          show_hdr;
    logic [31:0] len;
    r = '0;
    show_hdr = 1'b0;
    case (it.cmd)
      crcfr_pkg::CMD_RX_BYTE: begin
        if (!awaiting_reply) begin
          if (bytes_seen == 0) frame_start_time = it.now_time;
          if (bytes_seen < crcfr_pkg::HEADER_BYTES) begin
            hdr_bytes[bytes_seen] = it.rx_byte;
            bytes_seen++;
            if (bytes_seen == crcfr_pkg::HEADER_BYTES) begin
              show_hdr = 1'b1;
              len = hdr_word(16);
              if (!header_intact()) r.status_code = crcfr_pkg::ST_BAD_HEADER;
              else if (len > limit_now()) r.status_code = crcfr_pkg::ST_TOO_LONG;
              else begin
                frame_end_count = crcfr_pkg::HEADER_BYTES + len;
                payload_crc = crcfr_pkg::CRC_ONES;
              end
            end
          end else begin
            show_hdr = 1'b1;
            r.payload_valid = 1'b1;
            r.payload_byte = it.rx_byte;
            r.payload_offset = 12'(bytes_seen - crcfr_pkg::HEADER_BYTES);
            payload_crc = crc_step(payload_crc, it.rx_byte);
            bytes_seen++;
          end
          // the frame ends when the count reaches the frame end, for an empty payload on the last header byte
          if (r.status_code == crcfr_pkg::ST_NONE && bytes_seen >= crcfr_pkg::HEADER_BYTES &&
              bytes_seen == frame_end_count)
            r.status_code = ((~payload_crc) == hdr_word(20)) ? crcfr_pkg::ST_FRAME_OK
                                                             : crcfr_pkg::ST_CRC_BAD;
        end
      end
      crcfr_pkg::CMD_POLL: begin
        if (bytes_seen != 0 && (it.now_time - frame_start_time) > cfg_timeout) begin
          r.status_code = crcfr_pkg::ST_TIMEOUT;
          show_hdr = bytes_seen >= crcfr_pkg::HEADER_BYTES;
        end
      end
      crcfr_pkg::CMD_REPLY_SENT: awaiting_reply = 1'b0;
      crcfr_pkg::CMD_DISCONNECT: begin
        bytes_seen = 0;
        frame_end_count = crcfr_pkg::HEADER_BYTES;
        payload_crc = crcfr_pkg::CRC_ONES;
        awaiting_reply = 1'b0;
      end
      default: ;
    endcase
    if (r.status_code != crcfr_pkg::ST_NONE) begin
      if (r.status_code != crcfr_pkg::ST_FRAME_OK) reject_total++;
      awaiting_reply = 1'b1;
      bytes_seen = 0;
      frame_end_count = crcfr_pkg::HEADER_BYTES;
      payload_crc = crcfr_pkg::CRC_ONES;
    end
    if (show_hdr) begin
      len = hdr_word(16);
      r.frame_command = hdr_word(4);
      r.request_id = hdr_word(8);
      r.frame_sequence = hdr_word(12);
      r.payload_length = (len > 32'(crcfr_pkg::LEN_CAP)) ? crcfr_pkg::LEN_CAP
                                                         : crcfr_pkg::count_t'(len);
    end
    r.rejected_count = reject_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      // keep the log readable on a badly broken build
      if (mismatch_count <= 100)
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic int pick_len();
    int cap;
    cap = ($urandom_range(0, 9) == 0) ? 300 : 40;
    if (limit_now() < cap) cap = limit_now();
    return $urandom_range(0, cap);
  endfunction

  function automatic logic [31:0] over_limit_len();
    if ($urandom_range(0, 1)) return 32'(limit_now()) + 1 + $urandom_range(0, 3);
    return $urandom | 32'h0000_2000;
  endfunction

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin : result_check
    crcfr_pkg::result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, status %0d", $time, out_if.status_code);
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        status_tally[int'(want.status_code)]++;
        check_field("status_code", want.status_code, out_if.status_code);
        check_field("payload_valid", want.payload_valid, out_if.payload_valid);
        check_field("payload_byte", want.payload_byte, out_if.payload_byte);
        check_field("payload_offset", want.payload_offset, out_if.payload_offset);
        check_field("frame_command", want.frame_command, out_if.frame_command);
        check_field("request_id", want.request_id, out_if.request_id);
        check_field("frame_sequence", want.frame_sequence, out_if.frame_sequence);
        check_field("payload_length", want.payload_length, out_if.payload_length);
        check_field("rejected_count", want.rejected_count, out_if.rejected_count);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding", $time, CYCLE_LIMIT,
               awaited_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input crcfr_pkg::cmd_t op, input logic [7:0] data);
    crcfr_pkg::item_t it;
    int    gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.cmd = op;
    it.rx_byte = data;
    it.now_time = clock_now;
    in_if.valid <= 1'b1;
    in_if.cmd <= op;
    in_if.rx_byte <= data;
    in_if.now_time <= clock_now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    awaited_results.push_back(receiver_response(it));
    items_sent++;
    clock_now += $urandom_range(0, 2);
  endtask

  task automatic send_frame(input frame_flaw_t flaw, input logic [31:0] len, input int cut);
    logic [31:0] hdr_words [8];
    logic [7:0]  stream [$];
    logic [31:0] crc;
    int          n;
    crc = crcfr_pkg::CRC_ONES;
    if (flaw == FLAW_NONE || flaw == FLAW_PAYLOAD_CRC) begin
      for (int i = 0; i < int'(len); i++) begin
        stream.push_back(8'($urandom));
        crc = crc_step(crc, stream[i]);
      end
    end
    hdr_words[0] = crcfr_pkg::MAGIC_WORD;
    if (flaw == FLAW_MAGIC) hdr_words[0] ^= 32'd1 << $urandom_range(0, 31);
    hdr_words[1] = $urandom;
    hdr_words[2] = $urandom;
    hdr_words[3] = $urandom;
    hdr_words[4] = len;
    hdr_words[5] = ~crc;
    if (flaw == FLAW_PAYLOAD_CRC) hdr_words[5] ^= 32'd1 << $urandom_range(0, 31);
    hdr_words[6] = crcfr_pkg::VERSION_WORD;
    if (flaw == FLAW_VERSION) begin
      hdr_words[6] = $urandom;
      if (hdr_words[6] == crcfr_pkg::VERSION_WORD) hdr_words[6] = 32'd0;
    end
    // header goes in front of the payload bytes already queued
    for (int w = 6; w >= 0; w--)
      for (int k = 3; k >= 0; k--) stream.push_front(hdr_words[w][8*k +: 8]);
    crc = crcfr_pkg::CRC_ONES;
    for (int i = 0; i < int'(crcfr_pkg::HCRC_BYTES); i++) crc = crc_step(crc, stream[i]);
    hdr_words[7] = ~crc;
    if (flaw == FLAW_HEADER_CRC) hdr_words[7] ^= 32'd1 << $urandom_range(0, 31);
    for (int k = 3; k >= 0; k--) stream.insert(crcfr_pkg::HCRC_BYTES, hdr_words[7][8*k +: 8]);
    n = (cut < 0) ? stream.size() : cut;
    for (int i = 0; i < n; i++) send_item(crcfr_pkg::CMD_RX_BYTE, stream[i]);
  endtask

  task automatic send_reply();
    send_item(crcfr_pkg::CMD_REPLY_SENT, 8'($urandom));
  endtask

  task automatic send_poll();
    send_item(crcfr_pkg::CMD_POLL, 8'($urandom));
  endtask

  // bring the link back to a clean frame boundary
  task automatic clear_pending_frame();
    if (awaiting_reply) send_reply();
    if (bytes_seen != 0) send_item(crcfr_pkg::CMD_DISCONNECT, 8'($urandom));
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic sel);
    logic [31:0] data;
    apb_access(1'b0, sel, 32'd0, data);
    if (sel == crcfr_pkg::REG_MAX_PAYLOAD)
      check_field("max_payload_bytes", 32'(cfg_max_payload), data);
    else check_field("timeout_ticks", cfg_timeout, data);
  endtask

  task automatic program_register(input logic sel, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, sel, value, unused);
    if (sel == crcfr_pkg::REG_MAX_PAYLOAD) cfg_max_payload = value[crcfr_pkg::COUNT_W-1:0];
    else cfg_timeout = value;
    check_register(sel);
  endtask

  task automatic test_register_access();
    check_register(crcfr_pkg::REG_MAX_PAYLOAD);
    check_register(crcfr_pkg::REG_TIMEOUT);
    program_register(crcfr_pkg::REG_MAX_PAYLOAD, 32'(crcfr_pkg::MAX_PAYLOAD_RESET));
    program_register(crcfr_pkg::REG_TIMEOUT, crcfr_pkg::TIMEOUT_RESET);
  endtask

  task automatic test_good_frames();
    send_poll();
    send_reply();
    send_frame(FLAW_NONE, 0, -1);
    send_reply();
    send_frame(FLAW_NONE, 5, -1);
    send_reply();
  endtask

  task automatic test_header_checks();
    send_frame(FLAW_MAGIC, 4, -1);
    // bytes and polls while the reply is outstanding go nowhere
    send_item(crcfr_pkg::CMD_RX_BYTE, 8'hff);
    send_item(crcfr_pkg::CMD_RX_BYTE, 8'h00);
    send_poll();
    send_reply();
    send_frame(FLAW_VERSION, 2, -1);
    send_reply();
    send_frame(FLAW_HEADER_CRC, 3, -1);
    send_reply();
    send_frame(FLAW_LENGTH, 32'(limit_now()) + 1, -1);
    send_reply();
    send_frame(FLAW_LENGTH, 32'hffff_ffff, -1);
    send_reply();
  endtask

  task automatic test_payload_crc();
    send_frame(FLAW_PAYLOAD_CRC, 7, -1);
    send_reply();
    send_frame(FLAW_PAYLOAD_CRC, 1, -1);
    send_reply();
  endtask

  task automatic test_timeouts();
    // partial header, then polls across the timestamp wrap
    clock_now = 32'hffff_fff0;
    send_frame(FLAW_NONE, 4, 6);
    clock_now = frame_start_time + cfg_timeout;
    send_poll();
    clock_now = frame_start_time + cfg_timeout + 1;
    send_poll();
    send_item(crcfr_pkg::CMD_RX_BYTE, 8'h4b);
    send_reply();
    // stalled in the payload, header fields come with the report
    send_frame(FLAW_NONE, 8, crcfr_pkg::HEADER_BYTES + 4);
    clock_now = frame_start_time + cfg_timeout + 9;
    send_poll();
    send_reply();
    send_frame(FLAW_NONE, 8, 10);
    send_item(crcfr_pkg::CMD_DISCONNECT, 8'($urandom));
    send_frame(FLAW_NONE, 3, -1);
    send_reply();
  endtask

  task automatic test_config_extremes();
    wait_for_results();
    program_register(crcfr_pkg::REG_MAX_PAYLOAD, 32'd0);
    send_frame(FLAW_NONE, 0, -1);
    send_reply();
    send_frame(FLAW_LENGTH, 1, -1);
    send_reply();
    wait_for_results();
    // header at the cap is taken, then the frame is dropped a few bytes in
    program_register(crcfr_pkg::REG_MAX_PAYLOAD, 32'(crcfr_pkg::LEN_CAP));
    send_frame(FLAW_NONE, 32'(crcfr_pkg::LEN_CAP), crcfr_pkg::HEADER_BYTES + 8);
    send_item(crcfr_pkg::CMD_DISCONNECT, 8'($urandom));
    wait_for_results();
    // out-of-range limit behaves like the cap
    program_register(crcfr_pkg::REG_MAX_PAYLOAD, 32'hffff_ffff);
    send_frame(FLAW_LENGTH, 32'(crcfr_pkg::LEN_CAP) + 1, -1);
    send_reply();
    send_frame(FLAW_NONE, 9, -1);
    send_reply();
    wait_for_results();
    program_register(crcfr_pkg::REG_TIMEOUT, 32'd0);
    send_frame(FLAW_NONE, 6, 3);
    clock_now = frame_start_time;
    send_poll();
    clock_now = frame_start_time + 1;
    send_poll();
    send_reply();
    wait_for_results();
    program_register(crcfr_pkg::REG_TIMEOUT, 32'hffff_ffff);
    send_frame(FLAW_NONE, 10, 40);
    clock_now = frame_start_time - 1;
    send_poll();
    send_item(crcfr_pkg::CMD_DISCONNECT, 8'($urandom));
    wait_for_results();
    program_register(crcfr_pkg::REG_MAX_PAYLOAD, 32'(crcfr_pkg::MAX_PAYLOAD_RESET));
    program_register(crcfr_pkg::REG_TIMEOUT, crcfr_pkg::TIMEOUT_RESET);
  endtask

  task automatic test_result_backpressure();
    burst_mode = 1'b1;
    hold_req = 1'b1;
    for (int f = 0; f < 6; f++) begin
      send_frame(FLAW_NONE, 12, -1);
      send_reply();
    end
    burst_mode = 1'b0;
    // sender stops until the last result is out
    wait_for_results();
    send_frame(FLAW_NONE, 4, -1);
    send_reply();
  endtask

  task automatic test_random_traffic();
    int          phase_end;
    int          r;
    logic [31:0] value;
    logic [31:0] len;
    frame_flaw_t flaw;
    for (int phase = 0; phase < CONFIG_PHASES; phase++) begin
      wait_for_results();
      case ($urandom_range(0, 5))
        0: value = 32'd0;
        1: value = $urandom_range(1, 40);
        2: value = 32'(crcfr_pkg::MAX_PAYLOAD_RESET);
        3: value = 32'(crcfr_pkg::LEN_CAP);
        4: value = 32'h1fff;
        default: value = $urandom_range(0, 8191);
      endcase
      if ($urandom_range(0, 1)) value |= $urandom & 32'hffff_e000;
      program_register(crcfr_pkg::REG_MAX_PAYLOAD, value);
      case ($urandom_range(0, 4))
        0: value = 32'd0;
        1: value = $urandom_range(1, 60);
        2: value = crcfr_pkg::TIMEOUT_RESET;
        3: value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      program_register(crcfr_pkg::REG_TIMEOUT, value);
      phase_end = items_sent + RANDOM_ITEMS / CONFIG_PHASES;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        burst_mode = ($urandom_range(0, 7) == 0);
        if (r < 55) begin
          send_frame(FLAW_NONE, pick_len(), -1);
        end else if (r < 72) begin
          flaw = frame_flaw_t'($urandom_range(FLAW_MAGIC, FLAW_PAYLOAD_CRC));
          len = (flaw == FLAW_LENGTH) ? over_limit_len() : 32'(pick_len());
          send_frame(flaw, len, -1);
        end else if (r < 85) begin
          len = pick_len();
          send_frame(FLAW_NONE, len, $urandom_range(1, crcfr_pkg::HEADER_BYTES - 1 + len));
          if ($urandom_range(0, 1))
            clock_now = frame_start_time + cfg_timeout + 1 + $urandom_range(0, 40);
          send_poll();
        end else begin
          repeat ($urandom_range(1, 4))
            send_item(crcfr_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) clear_pending_frame();
      end
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_if.valid = 1'b0;
    in_if.cmd = crcfr_pkg::CMD_RX_BYTE;
    in_if.rx_byte = 8'd0;
    in_if.now_time = 32'd0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    for (int i = 0; i < crcfr_pkg::HEADER_BYTES; i++) hdr_bytes[i] = 8'd0;
    bytes_seen = 0;
    frame_end_count = crcfr_pkg::HEADER_BYTES;
    frame_start_time = 32'd0;
    awaiting_reply = 1'b0;
    reject_total = 32'd0;
    payload_crc = crcfr_pkg::CRC_ONES;
    cfg_max_payload = crcfr_pkg::MAX_PAYLOAD_RESET;
    cfg_timeout = crcfr_pkg::TIMEOUT_RESET;
    clock_now = $urandom;
    burst_mode = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    items_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    cycle_count = 0;
    for (int s = 0; s < 6; s++) status_tally[s] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_register_access();
    test_good_frames();
    test_header_checks();
    test_payload_crc();
    test_timeouts();
    test_config_extremes();
    test_result_backpressure();
    test_random_traffic();

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests, checked %0d results; %0d errors counted by the block",
             items_sent, results_checked, reject_total);
    $display("Reports: ok %0d, bad header %0d, too long %0d, payload crc %0d, timeout %0d",
             status_tally[crcfr_pkg::ST_FRAME_OK], status_tally[crcfr_pkg::ST_BAD_HEADER],
             status_tally[crcfr_pkg::ST_TOO_LONG], status_tally[crcfr_pkg::ST_CRC_BAD],
             status_tally[crcfr_pkg::ST_TIMEOUT]);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
